>>> hdl/go_to_goal_steering_defines.svh
// Assertion macros for the go-to-goal steering RTL.
`ifndef GO_TO_GOAL_STEERING_DEFINES_SVH
`define GO_TO_GOAL_STEERING_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define GTG_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define GTG_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/gtg_pkg.sv
// Shared constants, types and CORDIC helpers for the go-to-goal steering block.
`default_nettype none
package gtg_pkg;

   localparam int CORDIC_STEPS = 16;
   // capture, sums, pre-rotation, CORDIC, four post stages
   localparam int NUM_STAGES   = CORDIC_STEPS + 7;
   localparam int STG_POST     = CORDIC_STEPS + 3;

   localparam int CW = 44;   // CORDIC x/y width
   localparam int ZW = 34;   // CORDIC angle width, Q30

   localparam logic signed [ZW-1:0] PI_Q30     = 34'sd3373259426;
   localparam logic signed [17:0]   PI_Q13     = 18'sd25736;
   localparam logic signed [17:0]   TWO_PI_Q13 = 18'sd51472;
   localparam logic [15:0]          INV_GAIN   = 16'd39797;
   localparam logic signed [15:0]   PROG_ONE   = 16'sd16384;
   localparam logic signed [15:0]   PROG_MIN   = -16'sd32768;

   // register indexes
   localparam logic [2:0] REG_TARGET_X   = 3'd0;
   localparam logic [2:0] REG_TARGET_Y   = 3'd1;
   localparam logic [2:0] REG_GOAL_TOL   = 3'd2;
   localparam logic [2:0] REG_ANGLE_TOL  = 3'd3;
   localparam logic [2:0] REG_TURN_GAIN  = 3'd4;
   localparam logic [2:0] REG_FWD_SPEED  = 3'd5;
   localparam logic [2:0] REG_INV_MAXD   = 3'd6;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } vec_type;

   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:  r = 34'sh03243F6A8;
         5'd1:  r = 34'sh01DAC6705;
         5'd2:  r = 34'sh00FADBAFC;
         5'd3:  r = 34'sh007F56EA6;
         5'd4:  r = 34'sh003FEAB76;
         5'd5:  r = 34'sh001FFD55B;
         5'd6:  r = 34'sh000FFFAAA;
         5'd7:  r = 34'sh0007FFF55;
         5'd8:  r = 34'sh0003FFFEA;
         5'd9:  r = 34'sh0001FFFFD;
         5'd10: r = 34'sh0000FFFFF;
         5'd11: r = 34'sh00007FFFF;
         5'd12: r = 34'sh00003FFFF;
         5'd13: r = 34'sh00001FFFF;
         5'd14: r = 34'sh00000FFFF;
         5'd15: r = 34'sh000007FFF;
         5'd16: r = 34'sh000003FFF;
         5'd17: r = 34'sh000001FFF;
         5'd18: r = 34'sh000000FFF;
         5'd19: r = 34'sh0000007FF;
         5'd20: r = 34'sh0000003FF;
         5'd21: r = 34'sh0000001FF;
         5'd22: r = 34'sh0000000FF;
         5'd23: r = 34'sh00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Fold a left-half-plane vector into the right half plane.
   function automatic vec_type prerotate(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
      vec_type v;
      v.x = x;
      v.y = y;
      v.z = '0;
      if (x < 0) begin
         v.z = (y >= 0) ? PI_Q30 : -PI_Q30;
         v.x = -x;
         v.y = -y;
      end
      return v;
   endfunction

   // One vectoring micro-rotation; y == 0 leaves the vector as is.
   function automatic vec_type cordic_iter(input vec_type v, input logic [4:0] i);
      vec_type r;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      xs = v.x >>> i;
      ys = v.y >>> i;
      r  = v;
      if (v.y > 0) begin
         r.x = v.x + ys;
         r.y = v.y - xs;
         r.z = v.z + atan_q30(i);
      end else if (v.y < 0) begin
         r.x = v.x - ys;
         r.y = v.y + xs;
         r.z = v.z - atan_q30(i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/gtg_req_if.sv
// Pose input channel: valid/ready with position and quaternion.
`default_nettype none
interface gtg_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;
   modport source(output valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  input ready);
   modport sink(input valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                output ready);
endinterface
`default_nettype wire

>>> hdl/gtg_rsp_if.sv
// Command output channel: valid/ready with velocity commands and status.
`default_nettype none
interface gtg_rsp_if;
   logic               valid;
   logic               ready;
   logic [17:0]        linear_cmd;
   logic signed [16:0] angular_cmd;
   logic               goal_reached;
   logic signed [15:0] progress;
   modport source(output valid, linear_cmd, angular_cmd, goal_reached, progress,
                  input ready);
   modport sink(input valid, linear_cmd, angular_cmd, goal_reached, progress,
                output ready);
endinterface
`default_nettype wire

>>> hdl/gtg_csr_if.sv
// Register write channel: valid/ready with register index and data.
`default_nettype none
interface gtg_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [31:0] data;
   modport source(output valid, addr, data, input ready);
   modport sink(input valid, addr, data, output ready);
endinterface
`default_nettype wire

>>> hdl/go_to_goal_steering.sv
// Go-to-goal steering: pose in, velocity command out, fully pipelined.
//
// Channels: req_bus carries one odometry pose per transaction (Q16.16
// position, Q1.14 quaternion). rsp_bus returns one command per pose, in
// order: linear and angular command, goal_reached and progress.
// csr_bus writes the target and the tuning registers; it is always ready
// and should only be used while no pose is in flight.
// Pipeline: NUM_STAGES stages from the accepting edge to rsp_bus.valid.
// Throughput: one pose per cycle while rsp_bus is not stalling; the two
// vectoring CORDICs (bearing and yaw) run one micro-rotation per stage.
// Reset: synchronous, empties the pipeline and loads register defaults.
// Stall: each stage holds while the one after it is full and stalled, so
// a stalled output fills the pipe from the back; req_bus.ready drops only
// when every stage holds a pose. Nothing is dropped or repeated.
`default_nettype none
`include "go_to_goal_steering_defines.svh"
module go_to_goal_steering import gtg_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   gtg_req_if.sink    req_bus,
   gtg_rsp_if.source  rsp_bus,
   gtg_csr_if.sink    csr_bus
);

   // configuration registers
   logic signed [31:0] tgt_x_ff, tgt_y_ff;
   logic [19:0]        gtol_ff;
   logic [14:0]        atol_ff;
   logic [15:0]        gain_ff;
   logic [17:0]        fspd_ff;
   logic [15:0]        invd_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_x_ff <= '0;
         tgt_y_ff <= '0;
         gtol_ff  <= 20'd13107;
         atol_ff  <= 15'd819;
         gain_ff  <= 16'd16384;
         fspd_ff  <= 18'd19661;
         invd_ff  <= 16'd8192;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            REG_TARGET_X:  tgt_x_ff <= csr_bus.data;
            REG_TARGET_Y:  tgt_y_ff <= csr_bus.data;
            REG_GOAL_TOL:  gtol_ff  <= csr_bus.data[19:0];
            REG_ANGLE_TOL: atol_ff  <= csr_bus.data[14:0];
            REG_TURN_GAIN: gain_ff  <= csr_bus.data[15:0];
            REG_FWD_SPEED: fspd_ff  <= csr_bus.data[17:0];
            REG_INV_MAXD:  invd_ff  <= csr_bus.data[15:0];
            default: ;
         endcase
      end
   end

   // stage valid bits and per-stage advance
   logic [NUM_STAGES-1:0] vld_ff, vld_in, adv;

   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_bus.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      vld_in[0] = adv[0] ? req_bus.valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = adv[0];

   // stage 0: offsets and quaternion products
   logic signed [32:0] dx0_ff, dy0_ff;
   logic signed [31:0] pxx_ff, pyy_ff, pzz_ff, pww_ff, pxz_ff, pwy_ff, pxy_ff, pwz_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dx0_ff <= 33'(tgt_x_ff) - 33'(req_bus.pos_x);
         dy0_ff <= 33'(tgt_y_ff) - 33'(req_bus.pos_y);
         pxx_ff <= req_bus.quat_x * req_bus.quat_x;
         pyy_ff <= req_bus.quat_y * req_bus.quat_y;
         pzz_ff <= req_bus.quat_z * req_bus.quat_z;
         pww_ff <= req_bus.quat_w * req_bus.quat_w;
         pxz_ff <= req_bus.quat_x * req_bus.quat_z;
         pwy_ff <= req_bus.quat_w * req_bus.quat_y;
         pxy_ff <= req_bus.quat_x * req_bus.quat_y;
         pwz_ff <= req_bus.quat_w * req_bus.quat_z;
      end
   end

   // stage 1: yaw vector, norm and gimbal term
   logic signed [32:0] dx1_ff, dy1_ff;
   logic signed [33:0] nrm_ff, yvx_ff;
   logic signed [34:0] gim_ff, yvy_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         dx1_ff <= dx0_ff;
         dy1_ff <= dy0_ff;
         nrm_ff <= 34'(pxx_ff) + 34'(pyy_ff) + 34'(pzz_ff) + 34'(pww_ff);
         yvx_ff <= 34'(pww_ff) + 34'(pxx_ff) - 34'(pyy_ff) - 34'(pzz_ff);
         gim_ff <= (35'(pxz_ff) - 35'(pwy_ff)) <<< 1;
         yvy_ff <= (35'(pxy_ff) + 35'(pwz_ff)) <<< 1;
      end
   end

   // stage 2: scale, pre-rotate both vectors, yaw validity
   vec_type              cb_ff[CORDIC_STEPS+1];
   vec_type              cy_ff[CORDIC_STEPS+1];
   logic                 yok_ff[CORDIC_STEPS+1];
   logic signed [34:0]   gim_abs;

   assign gim_abs = (gim_ff < 0) ? -gim_ff : gim_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         cb_ff[0]  <= prerotate(CW'(dx1_ff) <<< 8, CW'(dy1_ff) <<< 8);
         cy_ff[0]  <= prerotate(CW'(yvx_ff) <<< 8, CW'(yvy_ff) <<< 8);
         yok_ff[0] <= gim_abs < 35'(nrm_ff);
      end
   end

   // CORDIC stages: one micro-rotation per stage on both lanes
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv[3+i]) begin
            cb_ff[i+1]  <= cordic_iter(cb_ff[i], 5'(i));
            cy_ff[i+1]  <= cordic_iter(cy_ff[i], 5'(i));
            yok_ff[i+1] <= yok_ff[i];
         end
      end
   end

   // post 1: gain-correction partial products, angles to Q13
   logic [42:0]        mag;
   logic signed [ZW-1:0] brg_rnd, yaw_rnd;
   logic [37:0]        phi_ff;
   logic [36:0]        plo_ff;
   logic signed [16:0] brg_ff, yaw_ff;

   assign mag     = cb_ff[CORDIC_STEPS].x[42:0];
   assign brg_rnd = cb_ff[CORDIC_STEPS].z + 34'sd65536;
   assign yaw_rnd = cy_ff[CORDIC_STEPS].z + 34'sd65536;

   always_ff @(posedge clock) begin
      if (adv[STG_POST]) begin
         phi_ff <= mag[42:21] * INV_GAIN;
         plo_ff <= mag[20:0] * INV_GAIN;
         brg_ff <= brg_rnd[33:17];
         yaw_ff <= yok_ff[CORDIC_STEPS] ? yaw_rnd[33:17] : 17'sd0;
      end
   end

   // post 2: distance and wrapped heading error
   logic [59:0]        dsum;
   logic signed [17:0] eraw, ewrap;
   logic [34:0]        dist_ff;
   logic signed [17:0] err_ff;

   assign dsum = {phi_ff, 21'd0} + 60'(plo_ff) + 60'd8388608;
   assign eraw = 18'(brg_ff) - 18'(yaw_ff);

   always_comb begin
      ewrap = eraw;
      if (eraw > PI_Q13) begin
         ewrap = eraw - TWO_PI_Q13;
      end else if (eraw < -PI_Q13) begin
         ewrap = eraw + TWO_PI_Q13;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[STG_POST+1]) begin
         dist_ff <= dsum[58:24];
         err_ff  <= ewrap;
      end
   end

   // post 3: decisions and output products
   logic signed [17:0] eabs;
   logic               reach_ff, turn_ff;
   logic signed [34:0] angp_ff;
   logic [50:0]        progp_ff;

   assign eabs = (err_ff < 0) ? -err_ff : err_ff;

   always_ff @(posedge clock) begin
      if (adv[STG_POST+2]) begin
         reach_ff <= dist_ff < 35'(gtol_ff);
         turn_ff  <= eabs > $signed(18'(atol_ff));
         angp_ff  <= $signed({1'b0, gain_ff}) * err_ff;
         progp_ff <= dist_ff * invd_ff;
      end
   end

   // post 4: round, saturate, select into the output register
   logic signed [35:0] ang_rnd;
   logic signed [20:0] ang_shf;
   logic signed [16:0] ang_sat;
   logic [51:0]        prg_rnd;
   logic [33:0]        scaled;
   logic signed [15:0] prog_val;
   logic [17:0]        lin_ff;
   logic signed [16:0] ang_ff;
   logic               reached_ff;
   logic signed [15:0] prog_ff;

   assign ang_rnd = 36'(angp_ff) + 36'sd16384;
   assign ang_shf = ang_rnd[35:15];
   assign prg_rnd = 52'(progp_ff) + 52'd131072;
   assign scaled  = prg_rnd[51:18];

   always_comb begin
      if (ang_shf > 21'sd65535) begin
         ang_sat = 17'sd65535;
      end else if (ang_shf < -21'sd65536) begin
         ang_sat = -17'sd65536;
      end else begin
         ang_sat = ang_shf[16:0];
      end
      if (scaled > 34'd49152) begin
         prog_val = PROG_MIN;
      end else begin
         prog_val = PROG_ONE - $signed(scaled[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NUM_STAGES-1]) begin
         if (reach_ff) begin
            lin_ff     <= '0;
            ang_ff     <= '0;
            reached_ff <= 1'b1;
            prog_ff    <= PROG_ONE;
         end else begin
            lin_ff     <= turn_ff ? 18'd0 : fspd_ff;
            ang_ff     <= turn_ff ? ang_sat : 17'sd0;
            reached_ff <= 1'b0;
            prog_ff    <= prog_val;
         end
      end
   end

   assign rsp_bus.valid        = vld_ff[NUM_STAGES-1];
   assign rsp_bus.linear_cmd   = lin_ff;
   assign rsp_bus.angular_cmd  = ang_ff;
   assign rsp_bus.goal_reached = reached_ff;
   assign rsp_bus.progress     = prog_ff;

   // checks
   `GTG_ASSERT_IMP(a_goal_stop, rsp_bus.valid && rsp_bus.goal_reached, rsp_bus.linear_cmd == 18'd0 && rsp_bus.angular_cmd == 17'sd0 && rsp_bus.progress == PROG_ONE, "goal reached with nonzero command")
   `GTG_ASSERT_IMP(a_drive_or_turn, rsp_bus.valid && rsp_bus.linear_cmd != 18'd0, rsp_bus.angular_cmd == 17'sd0, "drive and turn at once")
   `GTG_ASSERT_IMP(a_prog_max, rsp_bus.valid, rsp_bus.progress <= PROG_ONE, "progress above one")
   `GTG_ASSERT_NXT(a_stage0_hold, vld_ff[0] && !adv[0], vld_ff[0], "stalled pose lost in first stage")

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for go_to_goal_steering: pose stimulus, command prediction and checking.
`default_nettype none
module tb_top import gtg_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   // out-of-range register index, ignored by the block
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } pose_type;

   typedef struct {
      logic [17:0]        linear_cmd;
      logic signed [16:0] angular_cmd;
      logic               goal_reached;
      logic signed [15:0] progress;
   } steer_cmd_type;

   // Predicts one steering command per pose and checks commands in order
   class steer_scoreboard;
      longint          tgt_x, tgt_y;
      longint unsigned goal_tol, ang_tol, gain, fwd, inv_maxd;
      steer_cmd_type   cmd_q[$];
      int              errors;
      longint          atan_tab[24] = '{
         'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
         'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
         'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
         'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F};

      function void load_defaults();
         tgt_x = 0; tgt_y = 0; goal_tol = 13107; ang_tol = 819;
         gain = 16384; fwd = 19661; inv_maxd = 8192;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_TARGET_X:  tgt_x = longint'(signed'(val));
            REG_TARGET_Y:  tgt_y = longint'(signed'(val));
            REG_GOAL_TOL:  goal_tol = val[19:0];
            REG_ANGLE_TOL: ang_tol = val[14:0];
            REG_TURN_GAIN: gain = val[15:0];
            REG_FWD_SPEED: fwd = val[17:0];
            REG_INV_MAXD:  inv_maxd = val[15:0];
            default: ;
         endcase
      endfunction

      // vectoring CORDIC: magnitude (scaled by K and 256) and Q30 angle
      function void cordic_vector(longint x_in, longint y_in,
                                  output longint mag, output longint ang);
         longint x, y, z, xs, ys;
         x = x_in * 256;
         y = y_in * 256;
         z = 0;
         mag = 0;
         ang = 0;
         if (x == 0 && y == 0) return;
         if (x < 0) begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys; y = y - xs; z = z + atan_tab[i];
            end else if (y < 0) begin
               x = x - ys; y = y + xs; z = z - atan_tab[i];
            end
         end
         mag = x;
         ang = z;
      endfunction

      function void note_pose(pose_type p);
         steer_cmd_type c;
         longint mag, bear30, yaw30, unused, bearing, yaw, err, aerr, ang;
         longint qx, qy, qz, qw, n, e, prog;
         longint unsigned dist_q16, scaled;
         qx = p.quat_x; qy = p.quat_y; qz = p.quat_z; qw = p.quat_w;
         cordic_vector(tgt_x - longint'(p.pos_x), tgt_y - longint'(p.pos_y), mag, bear30);
         dist_q16 = (longint'(unsigned'(mag)) * 64'd39797 + (64'd1 << 23)) >> 24;
         if (dist_q16 < goal_tol) begin
            c = '{linear_cmd: 0, angular_cmd: 0, goal_reached: 1, progress: 16384};
            cmd_q.push_back(c);
            return;
         end
         // yaw, with gimbal lock and zero quaternion giving zero
         yaw30 = 0;
         n = qx*qx + qy*qy + qz*qz + qw*qw;
         e = 2 * (qx*qz - qw*qy);
         if (e < 0) e = -e;
         if (e < n)
            cordic_vector(qw*qw + qx*qx - qy*qy - qz*qz, 2 * (qx*qy + qw*qz), unused, yaw30);
         bearing = (bear30 + 65536) >>> 17;
         yaw = (yaw30 + 65536) >>> 17;
         err = bearing - yaw;
         if (err > 25736) err -= 51472;
         else if (err < -25736) err += 51472;
         aerr = (err < 0) ? -err : err;
         c.goal_reached = 0;
         if (aerr > longint'(ang_tol)) begin
            ang = (longint'(gain) * err + 16384) >>> 15;
            if (ang > 65535) ang = 65535;
            if (ang < -65536) ang = -65536;
            c.angular_cmd = ang[16:0];
            c.linear_cmd = 0;
         end else begin
            c.angular_cmd = 0;
            c.linear_cmd = fwd[17:0];
         end
         scaled = (dist_q16 * inv_maxd + (64'd1 << 17)) >> 18;
         prog = (scaled > 49152) ? -32768 : 16384 - longint'(scaled);
         c.progress = prog[15:0];
         cmd_q.push_back(c);
      endfunction

      function void check_cmd(steer_cmd_type got);
         steer_cmd_type exp_c;
         if (cmd_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected command transaction at %0t", $realtime);
            return;
         end
         exp_c = cmd_q.pop_front();
         if (got.linear_cmd !== exp_c.linear_cmd || got.angular_cmd !== exp_c.angular_cmd ||
             got.goal_reached !== exp_c.goal_reached || got.progress !== exp_c.progress) begin
            errors++;
            if (errors <= 10)
               $display({"cmd mismatch at %0t: exp lin=%0d ang=%0d goal=%0d prog=%0d",
                         " got lin=%0d ang=%0d goal=%0d prog=%0d"},
                        $realtime, exp_c.linear_cmd, exp_c.angular_cmd, exp_c.goal_reached,
                        exp_c.progress, got.linear_cmd, got.angular_cmd, got.goal_reached,
                        got.progress);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   gtg_req_if req_bus();
   gtg_rsp_if rsp_bus();
   gtg_csr_if csr_bus();

   go_to_goal_steering u_top (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   steer_scoreboard sb = new();
   int idle_pct = 24;
   bit hold_go = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // monitors: note accepted poses, check accepted commands
   always @(posedge clock) begin
      pose_type p;
      steer_cmd_type c;
      if (!reset && req_bus.valid && req_bus.ready) begin
         p.pos_x = req_bus.pos_x;   p.pos_y = req_bus.pos_y;
         p.quat_x = req_bus.quat_x; p.quat_y = req_bus.quat_y;
         p.quat_z = req_bus.quat_z; p.quat_w = req_bus.quat_w;
         sb.note_pose(p);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         c.linear_cmd = rsp_bus.linear_cmd;     c.angular_cmd = rsp_bus.angular_cmd;
         c.goal_reached = rsp_bus.goal_reached; c.progress = rsp_bus.progress;
         sb.check_cmd(c);
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else
            rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic send_pose(pose_type p);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pos_x <= p.pos_x;   req_bus.pos_y <= p.pos_y;
      req_bus.quat_x <= p.quat_x; req_bus.quat_y <= p.quat_y;
      req_bus.quat_z <= p.quat_z; req_bus.quat_w <= p.quat_w;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic end_burst();
      req_bus.valid <= 1'b0;
      while (sb.cmd_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.addr <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.write_reg(idx, val);
   endtask

   task automatic write_all(logic [31:0] tx, logic [31:0] ty, logic [31:0] gt,
                            logic [31:0] at, logic [31:0] tg, logic [31:0] fs,
                            logic [31:0] im);
      write_csr(REG_TARGET_X, tx);  write_csr(REG_TARGET_Y, ty);
      write_csr(REG_GOAL_TOL, gt);  write_csr(REG_ANGLE_TOL, at);
      write_csr(REG_TURN_GAIN, tg); write_csr(REG_FWD_SPEED, fs);
      write_csr(REG_INV_MAXD, im);
   endtask

   function automatic logic signed [15:0] rand_quat();
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: return 16'sd16384;
         2: return -16'sd16384;
         default: return 16'($signed($urandom_range(32768)) - 16384);
      endcase
   endfunction

   // random pose: near target, moderate, or fully random position
   function automatic pose_type rand_pose();
      pose_type p;
      int sel;
      sel = $urandom_range(9);
      if (sel < 3) begin
         p.pos_x = 32'(sb.tgt_x + $signed($urandom_range(40000)) - 20000);
         p.pos_y = 32'(sb.tgt_y + $signed($urandom_range(40000)) - 20000);
      end else if (sel < 7) begin
         p.pos_x = 32'(sb.tgt_x + $signed($urandom_range(2000000)) - 1000000);
         p.pos_y = 32'(sb.tgt_y + $signed($urandom_range(2000000)) - 1000000);
      end else begin
         p.pos_x = $urandom;
         p.pos_y = $urandom;
      end
      p.quat_x = rand_quat(); p.quat_y = rand_quat();
      p.quat_z = rand_quat(); p.quat_w = rand_quat();
      if ($urandom_range(19) == 0) begin
         // gimbal lock: x = z, y = w = 0
         p.quat_x = rand_quat(); p.quat_z = p.quat_x; p.quat_y = 0; p.quat_w = 0;
      end
      return p;
   endfunction

   task automatic random_burst(int count);
      for (int i = 0; i < count; i++) send_pose(rand_pose());
      end_burst();
   endtask

   task automatic directed_poses();
      pose_type p;
      p = '{0, 0, 0, 0, 0, 16384};             send_pose(p); // at goal
      p = '{0, 0, 0, 0, 0, 0};                 send_pose(p); // zero offset, zero quat
      p = '{32'sh7FFFFFFF, 32'sh80000000, 16384, 0, 16384, 0}; send_pose(p);
      p = '{32'sh80000000, 32'sh7FFFFFFF, -16384, -16384, -16384, -16384}; send_pose(p);
      p = '{32'sh80000000, 0, 0, 0, 16384, 0};  send_pose(p); // offset on +x
      p = '{32'sh7FFFFFFF, 0, 0, 0, 0, 16384};  send_pose(p); // offset on -x
      p = '{32'sh7FFFFFFF, 1, 0, 0, 0, 16384};  send_pose(p); // -x, y<0
      p = '{32'sh7FFFFFFF, -1, 0, 0, 0, 16384}; send_pose(p); // -x, y>0
      p = '{0, 32'sh80000000, 0, 0, 11585, 11585}; send_pose(p);
      p = '{-65536, 65536, 0, 0, 16384, 0};     send_pose(p); // turn
      p = '{-65536, 0, 0, 0, 0, 16384};         send_pose(p); // aligned
      p = '{13107, 0, 0, 0, 0, 16384};          send_pose(p); // tolerance edge
      p = '{13100, 0, 0, 0, 0, 16384};          send_pose(p);
      p = '{-65536, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}; send_pose(p);
      p = '{-65536, 0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF}; send_pose(p);
      p = '{-65536, 0, 100, 0, 0, 0};           send_pose(p);
      p = '{32'sh55555555, 32'shAAAAAAAA, 16'sh5555, 16'shAAAA, 16'sh2AAA, 16'sh5555};
      send_pose(p);
      end_burst();
   endtask

   // main sequence
   initial begin
      sb.load_defaults();
      reset = 1;
      req_bus.valid = 0; req_bus.pos_x = 0; req_bus.pos_y = 0;
      req_bus.quat_x = 0; req_bus.quat_y = 0; req_bus.quat_z = 0; req_bus.quat_w = 0;
      csr_bus.valid = 0; csr_bus.addr = 0; csr_bus.data = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed_poses();
      random_burst(150);

      // extremes: large tolerances and gains
      write_all(32'h7FFFFFFF, 32'h80000000, 32'hFFFFF, 25736, 32'hFFFF, 32'h3FFFF,
                32'hFFFF);
      write_csr(REG_UNUSED, 32'hFFFFFFFF);
      directed_poses();
      random_burst(120);

      // zero tolerances, minimum scale, no idling
      write_all(32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0, 1);
      idle_pct = 0;
      random_burst(150);
      idle_pct = 24;

      // long output hold-off while poses keep coming
      write_all(32'h00030000, 32'hFFFE0000, 13107, 819, 16384, 19661, 0);
      idle_pct = 0;
      hold_go = 1;
      random_burst(150);
      idle_pct = 24;

      for (int k = 0; k < 3; k++) begin
         write_all($urandom, $urandom, $urandom_range(200000), $urandom_range(25736),
                   $urandom_range(65535), $urandom_range(262143), $urandom_range(65535, 1));
         random_burst(150);
      end

      end_burst();
      if (sb.errors == 0 && sb.cmd_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
